// ===== rtl/core/fiba_pkg.sv =====
// fiba_pkg: request/response payload types, codes and shared constants for the
// file inode and block allocator. No dependencies.
package fiba_pkg;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_CREATE = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_FORMAT = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_EXISTS    = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [15:0] file_id;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  inode_slot;
        logic [7:0]  first_block;
        logic [7:0]  block_count;
    } rsp_t;

    // write control for the block map
    typedef struct packed {
        logic en;
        logic data;
    } blk_wr_t;

    // first_block is 8 bits: create only allocates below this block number
    localparam int MAX_START_BLOCKS = 256;

    // blocks reserved by format
    localparam int RESERVED_BLOCKS = 2;

endpackage

// ===== rtl/core/file_inode_and_block_allocator.sv =====
// file_inode_and_block_allocator: inode table and free block map with a
// sequencer that scans one entry per step. Depends on fiba_pkg, fiba_blkmap.
//
//  channel | dir | ports                         | transaction
//  --------+-----+-------------------------------+-----------------------------
//  s_      | in  | s_valid, s_ready, s_req       | one request (type, file id)
//  m_      | out | m_valid, m_ready, m_rsp       | one response per request
//
// Inode scan: stops at the first match (at most INODE_SLOTS slots).
// Create then probes up to min(DISK_BLOCKS,256) blocks for a free one, then writes.
// Delete then frees each block of the file in turn; format rewrites the whole block map.
// Everything is paced by the single read port of each table; one request at a time.
// After reset a clearing pass over the whole block map runs with s_ready low.
// A finished response waits in the output register; the next request is taken meanwhile.
module file_inode_and_block_allocator #(
    parameter int INODE_SLOTS = 16,
    parameter int DISK_BLOCKS = 256
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  fiba_pkg::req_t s_req,
    output logic           m_valid,
    input  logic           m_ready,
    output fiba_pkg::rsp_t m_rsp
);

    localparam int SW = (INODE_SLOTS > 1) ? $clog2(INODE_SLOTS) : 1;
    localparam int BW = $clog2(DISK_BLOCKS);
    localparam int SCAN_BLOCKS = (DISK_BLOCKS < fiba_pkg::MAX_START_BLOCKS) ?
                                 DISK_BLOCKS : fiba_pkg::MAX_START_BLOCKS;
    localparam logic [SW-1:0] LAST_SLOT = SW'(INODE_SLOTS - 1);
    localparam logic [BW-1:0] LAST_BLOCK = BW'(DISK_BLOCKS - 1);
    localparam logic [BW-1:0] LAST_SCAN = BW'(SCAN_BLOCKS - 1);
    localparam logic [BW-1:0] RSV_LIMIT = BW'(fiba_pkg::RESERVED_BLOCKS);
    localparam logic [12:0] DISK_LIMIT = 13'(DISK_BLOCKS);

    typedef struct packed {
        logic [15:0] file_id;
        logic [7:0]  start;
        logic [7:0]  count;
    } ino_entry_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_BLK_RD,
        S_BLK_CMP,
        S_CREATE,
        S_DELETE,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    fiba_pkg::req_t         req_reg, req_next;
    logic [INODE_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [SW-1:0]          idx_reg, idx_next;
    logic                   free_found_reg, free_found_next;
    logic [SW-1:0]          free_slot_reg, free_slot_next;
    logic [SW-1:0]          hit_slot_reg, hit_slot_next;
    logic [7:0]             start_reg, start_next;
    logic [7:0]             count_reg, count_next;
    logic [8:0]             pos_reg, pos_next;
    logic [7:0]             rem_reg, rem_next;
    logic [BW-1:0]          blk_reg, blk_next;
    logic                   fmt_reg, fmt_next;
    fiba_pkg::rsp_t         res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    fiba_pkg::rsp_t         m_rsp_reg, m_rsp_next;

    ino_entry_t             ino_mem [INODE_SLOTS];
    ino_entry_t             ino_rd_reg;
    logic                   ino_we;
    ino_entry_t             ino_wdata;

    fiba_pkg::blk_wr_t      blk_wr;
    logic [BW-1:0]          blk_waddr;
    logic                   blk_rd_data;

    logic                   cur_valid;
    logic                   cur_hit;
    logic                   free_now;
    logic [SW-1:0]          free_slot_now;
    logic                   pos_in_disk;

    fiba_blkmap #(
        .DEPTH(DISK_BLOCKS)
    ) u_blkmap (
        .aclk    (aclk),
        .wr      (blk_wr),
        .waddr   (blk_waddr),
        .raddr   (blk_reg),
        .rd_data (blk_rd_data)
    );

    // inode table: read address follows the scan index
    always_ff @(posedge aclk) begin
        if (ino_we) begin
            ino_mem[free_slot_reg] <= ino_wdata;
        end
        ino_rd_reg <= ino_mem[idx_reg];
    end

    assign cur_valid     = slot_valid_reg[idx_reg];
    assign cur_hit       = cur_valid && (ino_rd_reg.file_id == req_reg.file_id);
    assign free_now      = free_found_reg || !cur_valid;
    assign free_slot_now = free_found_reg ? free_slot_reg : idx_reg;
    assign pos_in_disk   = {4'b0, pos_reg} < DISK_LIMIT;

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        slot_valid_next = slot_valid_reg;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        hit_slot_next   = hit_slot_reg;
        start_next      = start_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        blk_next        = blk_reg;
        fmt_next        = fmt_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_rsp_next      = m_rsp_reg;
        ino_we          = 1'b0;
        ino_wdata       = '{file_id: req_reg.file_id, start: 8'(blk_reg), count: 8'd1};
        blk_wr          = '{en: 1'b0, data: 1'b0};
        blk_waddr       = blk_reg;

        unique case (state_reg)
            S_CLEAR: begin
                blk_wr = '{en: 1'b1, data: (blk_reg < RSV_LIMIT)};
                blk_next = blk_reg + 1'b1;
                if (blk_reg == LAST_BLOCK) begin
                    res_next   = '{fiba_pkg::STATUS_OK, 4'd0, 8'd0, 8'd0};
                    state_next = fmt_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    req_next = s_req;
                    if (s_req.req_type == fiba_pkg::REQ_FORMAT) begin
                        slot_valid_next = '0;
                        blk_next        = '0;
                        fmt_next        = 1'b1;
                        state_next      = S_CLEAR;
                    end else begin
                        idx_next        = '0;
                        free_found_next = 1'b0;
                        state_next      = S_FIND_RD;
                    end
                end
            end
            S_FIND_RD: begin
                state_next = S_FIND_CMP;
            end
            S_FIND_CMP: begin
                if (cur_hit || idx_reg == LAST_SLOT) begin
                    unique case (req_reg.req_type)
                        fiba_pkg::REQ_LOOKUP: begin
                            res_next = cur_hit ?
                                '{fiba_pkg::STATUS_OK, 4'(idx_reg),
                                  ino_rd_reg.start, ino_rd_reg.count} :
                                '{fiba_pkg::STATUS_NOT_FOUND, 4'd0, 8'd0, 8'd0};
                            state_next = S_DONE;
                        end
                        fiba_pkg::REQ_DELETE: begin
                            if (cur_hit) begin
                                hit_slot_next = idx_reg;
                                start_next    = ino_rd_reg.start;
                                count_next    = ino_rd_reg.count;
                                pos_next      = {1'b0, ino_rd_reg.start};
                                rem_next      = ino_rd_reg.count;
                                state_next    = S_DELETE;
                            end else begin
                                res_next   = '{fiba_pkg::STATUS_NOT_FOUND, 4'd0, 8'd0, 8'd0};
                                state_next = S_DONE;
                            end
                        end
                        fiba_pkg::REQ_CREATE: begin
                            if (cur_hit) begin
                                res_next   = '{fiba_pkg::STATUS_EXISTS, 4'd0, 8'd0, 8'd0};
                                state_next = S_DONE;
                            end else if (!free_now) begin
                                res_next   = '{fiba_pkg::STATUS_FULL, 4'd0, 8'd0, 8'd0};
                                state_next = S_DONE;
                            end else begin
                                free_slot_next = free_slot_now;
                                blk_next       = '0;
                                state_next     = S_BLK_RD;
                            end
                        end
                        fiba_pkg::REQ_FORMAT: begin
                            res_next   = '{fiba_pkg::STATUS_OK, 4'd0, 8'd0, 8'd0};
                            state_next = S_DONE;
                        end
                    endcase
                end else begin
                    free_found_next = free_now;
                    free_slot_next  = free_slot_now;
                    idx_next        = idx_reg + 1'b1;
                    state_next      = S_FIND_RD;
                end
            end
            S_BLK_RD: begin
                state_next = S_BLK_CMP;
            end
            S_BLK_CMP: begin
                if (!blk_rd_data) begin
                    state_next = S_CREATE;
                end else if (blk_reg == LAST_SCAN) begin
                    res_next   = '{fiba_pkg::STATUS_FULL, 4'd0, 8'd0, 8'd0};
                    state_next = S_DONE;
                end else begin
                    blk_next   = blk_reg + 1'b1;
                    state_next = S_BLK_RD;
                end
            end
            S_CREATE: begin
                ino_we = 1'b1;
                blk_wr = '{en: 1'b1, data: 1'b1};
                slot_valid_next[free_slot_reg] = 1'b1;
                res_next = '{fiba_pkg::STATUS_OK, 4'(free_slot_reg), 8'(blk_reg), 8'd1};
                state_next = S_DONE;
            end
            S_DELETE: begin
                blk_waddr = BW'(pos_reg);
                if (rem_reg == 8'd0) begin
                    slot_valid_next[hit_slot_reg] = 1'b0;
                    res_next = '{fiba_pkg::STATUS_OK, 4'(hit_slot_reg), start_reg, count_reg};
                    state_next = S_DONE;
                end else begin
                    // drop blocks that fall past the end of the disk
                    blk_wr   = '{en: pos_in_disk, data: 1'b0};
                    pos_next = pos_reg + 1'b1;
                    rem_next = rem_reg - 1'b1;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_rsp_next   = res_reg;
                    fmt_next     = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            slot_valid_reg <= '0;
            blk_reg        <= '0;
            fmt_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            blk_reg        <= blk_next;
            fmt_reg        <= fmt_next;
            free_found_reg <= free_found_next;
            m_valid_reg    <= m_valid_next;
        end
        req_reg       <= req_next;
        idx_reg       <= idx_next;
        free_slot_reg <= free_slot_next;
        hit_slot_reg  <= hit_slot_next;
        start_reg     <= start_next;
        count_reg     <= count_next;
        pos_reg       <= pos_next;
        rem_reg       <= rem_next;
        res_reg       <= res_next;
        m_rsp_reg     <= m_rsp_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    // the clearing pass follows every reset
    a_reset_clears : assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("block ready right after reset");

    a_one_at_a_time : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in progress");

    a_reserved_kept : assert property (@(posedge aclk) disable iff (!aresetn)
        blk_wr.en && !blk_wr.data && (blk_waddr < RSV_LIMIT) |-> state_reg == S_CLEAR)
        else $error("reserved block freed outside the clearing pass");

    a_rsp_from_done : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE))
        else $error("response raised without a finished request");

endmodule

// ===== rtl/core/fiba_blkmap.sv =====
// fiba_blkmap: used/free bit per disk block, one write and one registered read
// port. Depends on fiba_pkg (blk_wr_t).
module fiba_blkmap #(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  fiba_pkg::blk_wr_t wr,
    input  logic [AW-1:0]    waddr,
    input  logic [AW-1:0]    raddr,
    output logic             rd_data
);

    logic used_mem [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            used_mem[waddr] <= wr.data;
        end
        rd_data_reg <= used_mem[raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== tb/fiba_response_checker.sv =====
// fiba_response_checker: watches both channels of the file inode and block allocator,
// predicts each response from its own copy of the inode table and block map, and compares.
// Depends on fiba_pkg.
module fiba_response_checker #(
    parameter int INODE_SLOTS = 16,
    parameter int DISK_BLOCKS = 256
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  fiba_pkg::req_t s_req,
    input  logic           m_valid,
    input  logic           m_ready,
    input  fiba_pkg::rsp_t m_rsp,
    output int             fail_count,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;
    localparam int ALLOC_LIMIT =
        (DISK_BLOCKS < fiba_pkg::MAX_START_BLOCKS) ? DISK_BLOCKS : fiba_pkg::MAX_START_BLOCKS;

    // shadow of the file store
    logic [INODE_SLOTS-1:0] inode_used;
    logic [15:0]            inode_id    [INODE_SLOTS];
    logic [7:0]             inode_start [INODE_SLOTS];
    logic [7:0]             inode_len   [INODE_SLOTS];
    logic [DISK_BLOCKS-1:0] blk_busy;

    fiba_pkg::rsp_t pending_responses [$];
    int             errors = 0;

    task automatic format_store();
        int i;
        inode_used = '0;
        for (i = 0; i < INODE_SLOTS; i++) begin
            inode_id[i]    = '0;
            inode_start[i] = '0;
            inode_len[i]   = '0;
        end
        blk_busy = '0;
        for (i = 0; i < fiba_pkg::RESERVED_BLOCKS; i++) blk_busy[i] = 1'b1;
    endtask

    // lowest valid slot holding the id, or -1
    function automatic int find_file(logic [15:0] id);
        int i;
        for (i = 0; i < INODE_SLOTS; i++)
            if (inode_used[i] && inode_id[i] == id) return i;
        return -1;
    endfunction

    task automatic apply_fs_request(input fiba_pkg::req_t rq, output fiba_pkg::rsp_t rs);
        int hit, slot, blk, idx;
        rs = '0;
        rs.status = fiba_pkg::STATUS_OK;
        hit = find_file(rq.file_id);
        case (rq.req_type)
            fiba_pkg::REQ_LOOKUP, fiba_pkg::REQ_DELETE: begin
                if (hit < 0) begin
                    rs.status = fiba_pkg::STATUS_NOT_FOUND;
                end else begin
                    rs.inode_slot  = hit[3:0];
                    rs.first_block = inode_start[hit];
                    rs.block_count = inode_len[hit];
                    if (rq.req_type == fiba_pkg::REQ_DELETE) begin
                        // free only the part of the range that lies on the disk
                        for (idx = 0; idx < inode_len[hit]; idx++)
                            if (inode_start[hit] + idx < DISK_BLOCKS)
                                blk_busy[inode_start[hit] + idx] = 1'b0;
                        inode_used[hit]  = 1'b0;
                        inode_id[hit]    = '0;
                        inode_start[hit] = '0;
                        inode_len[hit]   = '0;
                    end
                end
            end
            fiba_pkg::REQ_CREATE: begin
                if (hit >= 0) begin
                    rs.status = fiba_pkg::STATUS_EXISTS;
                end else begin
                    slot = -1;
                    blk  = -1;
                    for (idx = INODE_SLOTS - 1; idx >= 0; idx--)
                        if (!inode_used[idx]) slot = idx;
                    for (idx = ALLOC_LIMIT - 1; idx >= 0; idx--)
                        if (!blk_busy[idx]) blk = idx;
                    if (slot < 0 || blk < 0) begin
                        rs.status = fiba_pkg::STATUS_FULL;
                    end else begin
                        inode_used[slot]  = 1'b1;
                        inode_id[slot]    = rq.file_id;
                        inode_start[slot] = blk[7:0];
                        inode_len[slot]   = 8'd1;
                        blk_busy[blk]     = 1'b1;
                        rs.inode_slot     = slot[3:0];
                        rs.first_block    = blk[7:0];
                        rs.block_count    = 8'd1;
                    end
                end
            end
            default: format_store();
        endcase
    endtask

    always @(posedge aclk) begin : watch
        fiba_pkg::rsp_t want;
        fiba_pkg::rsp_t got;
        if (!aresetn) begin
            format_store();
            pending_responses.delete();
        end else begin
            // retire the response first: it always belongs to an older request
            if (m_valid === 1'b1 && m_ready) begin
                got = m_rsp;
                if (pending_responses.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: response with no request outstanding: %p",
                                 $realtime, got);
                end else begin
                    want = pending_responses.pop_front();
                    if (got.status !== want.status || got.inode_slot !== want.inode_slot ||
                        got.first_block !== want.first_block ||
                        got.block_count !== want.block_count) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"%0t: mismatch status %0d/%0d slot %0d/%0d",
                                      " first %0d/%0d count %0d/%0d (exp/got)"},
                                     $realtime, want.status, got.status,
                                     want.inode_slot, got.inode_slot,
                                     want.first_block, got.first_block,
                                     want.block_count, got.block_count);
                    end
                end
            end
            if (s_valid && s_ready === 1'b1) begin
                apply_fs_request(s_req, want);
                pending_responses.push_back(want);
            end
        end
        pending    <= pending_responses.size();
        fail_count <= errors;
    end

endmodule

// ===== tb/file_inode_and_block_allocator_tb.sv =====
// file_inode_and_block_allocator_tb: drives requests and response back-pressure into the
// allocator and reports the verdict. Depends on fiba_pkg, fiba_response_checker and the RTL.
module file_inode_and_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM       = 725;
    localparam int POOL_SIZE      = 24;
    localparam int HOLD_OFF       = 2500;
    localparam int HOLD_AFTER     = 300;
    localparam int DRAIN_CYCLES   = 600;
    localparam int WATCHDOG_LIMIT = 20000;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    fiba_pkg::req_t s_req;
    logic           m_valid;
    logic           m_ready;
    fiba_pkg::rsp_t m_rsp;
    int             fail_count;
    int             pending;

    int   items_sent = 0;
    int   quiet_cycles = 0;
    bit   pressure_done = 1'b0;
    logic [15:0] id_pool [POOL_SIZE];

    file_inode_and_block_allocator DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    fiba_response_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rsp      (m_rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 15);
        else return $urandom_range(30, 80);
    endfunction

    function automatic fiba_pkg::req_t make_req(fiba_pkg::req_type_t kind, logic [15:0] id);
        fiba_pkg::req_t r;
        r.req_type = kind;
        r.file_id  = id;
        return r;
    endfunction

    // offer one transaction and hold it until accepted; returns at the accepting edge
    task automatic send_req(input fiba_pkg::req_t r, input bit burst);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        items_sent++;
    endtask

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : m_side
        int run, hold;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            // long hold-off while the sender keeps offering, so the input backs up
            if (!pressure_done && items_sent >= HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
                pressure_done = 1'b1;
            end
            run = $urandom_range(1, 40);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            hold = pick_gap();
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
        end
    end

    initial begin : s_side
        int k, roll, create_pct;
        bit burst;
        fiba_pkg::req_type_t kind;
        logic [15:0] id;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_req   <= '0;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (k = 2; k < POOL_SIZE; k++) id_pool[k] = 16'($urandom_range(0, 65535));
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, extreme ids, duplicate, reuse of freed slot, full table
        send_req(make_req(fiba_pkg::REQ_LOOKUP, 16'h0000), 1'b0);
        send_req(make_req(fiba_pkg::REQ_DELETE, 16'hFFFF), 1'b0);
        send_req(make_req(fiba_pkg::REQ_CREATE, 16'h0000), 1'b0);
        send_req(make_req(fiba_pkg::REQ_CREATE, 16'hFFFF), 1'b0);
        send_req(make_req(fiba_pkg::REQ_CREATE, 16'h0000), 1'b0);
        send_req(make_req(fiba_pkg::REQ_LOOKUP, 16'hFFFF), 1'b0);
        send_req(make_req(fiba_pkg::REQ_DELETE, 16'h0000), 1'b0);
        send_req(make_req(fiba_pkg::REQ_CREATE, 16'h1234), 1'b0);
        for (k = 0; k < 14; k++)
            send_req(make_req(fiba_pkg::REQ_CREATE, 16'h0100 + 16'(k)), 1'b1);
        send_req(make_req(fiba_pkg::REQ_CREATE, 16'hABCD), 1'b0);
        send_req(make_req(fiba_pkg::REQ_FORMAT, 16'hFFFF), 1'b0);
        send_req(make_req(fiba_pkg::REQ_LOOKUP, 16'hFFFF), 1'b0);

        // random: ids mostly from a small pool so hits, duplicates and full tables occur
        burst = 1'b0;
        create_pct = 30;
        for (k = 0; k < N_RANDOM; k++) begin
            if (k % 64 == 0) begin
                burst = ($urandom_range(0, 3) == 0);
                create_pct = ($urandom_range(0, 1) == 0) ? 30 : 60;
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) kind = fiba_pkg::REQ_FORMAT;
            else if (roll < 3 + create_pct) kind = fiba_pkg::REQ_CREATE;
            else if (roll < 3 + create_pct + (97 - create_pct) / 2) kind = fiba_pkg::REQ_LOOKUP;
            else kind = fiba_pkg::REQ_DELETE;
            if ($urandom_range(0, 99) < 85)
                id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                id = 16'($urandom_range(0, 65535));
            send_req(make_req(kind, id), burst);
        end
        s_valid <= 1'b0;

        // let the checker count the last accepted transaction before polling
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/fiba_pkg.sv
rtl/core/fiba_blkmap.sv
rtl/core/file_inode_and_block_allocator.sv
tb/fiba_response_checker.sv
tb/file_inode_and_block_allocator_tb.sv
